// ----- rtl/otqe_pkg.sv -----
// Shared types, codes and constants for the orphan table with quota eviction.
package otqe_pkg;

   localparam int DEF_ENTRIES    = 64;
   localparam int DEF_PEER_WIDTH = 16;
   localparam int MAX_RESULTS    = 64;

   localparam int OPCODE_W   = 2;
   localparam int TAG_W      = 64;
   localparam int PORT_PEER_W = 16;
   localparam int BYTES_W    = 24;
   localparam int REF_W      = 32;
   localparam int TICK_W     = 48;
   localparam int ORDER_W    = 32;
   localparam int TOTAL_W    = 30;
   localparam int CFG_CNT_W  = 7;
   localparam int RES_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TAKE     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CONTAINS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRY_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TOTAL_BYTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PEER_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PEER_BYTES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPIRY_TICKS    = 3'd4;

   localparam logic [CFG_CNT_W-1:0] RST_MAX_ENTRY_COUNT = 7'd64;
   localparam logic [TOTAL_W-1:0]   RST_MAX_TOTAL_BYTES = 30'd8388608;
   localparam logic [CFG_CNT_W-1:0] RST_MAX_PEER_COUNT  = 7'd16;
   localparam logic [BYTES_W-1:0]   RST_MAX_PEER_BYTES  = 24'd1048576;
   localparam logic [TICK_W-1:0]    RST_EXPIRY_TICKS    = 48'd1200;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_PASS_DONE,
      ST_CAPS,
      ST_FREE,
      ST_RESP,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PASS_EXPIRE,
      PASS_CHECK,
      PASS_EVICT,
      PASS_CONTAINS,
      PASS_COUNT,
      PASS_OLDEST
   } pass_type;

endpackage

// ----- rtl/otqe_store.sv -----
// Slot memory of the orphan table: one write port and one registered read port.
module otqe_store #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/orphan_table_quota_eviction.sv -----
// Top level of the orphan table: sequencer, slot scan unit and result register.
// Each request runs as full scans of the slot table, one slot at a time through the single
// read port of the slot memory: contains takes one scan; add takes an expiry scan and a
// check scan, one more scan per evicted entry, and then the free slot search; take takes
// an expiry scan and a count scan, and one more scan per child.
// One request at a time. Synchronous active-high reset empties the table at once.
module orphan_table_quota_eviction #(
   parameter int ENTRIES    = otqe_pkg::DEF_ENTRIES,
   parameter int PEER_WIDTH = otqe_pkg::DEF_PEER_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [otqe_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [otqe_pkg::TAG_W-1:0]        req_block_tag,
   input  logic [otqe_pkg::TAG_W-1:0]        req_variant_tag,
   input  logic [otqe_pkg::TAG_W-1:0]        req_parent_tag,
   input  logic [otqe_pkg::PORT_PEER_W-1:0]  req_peer_id,
   input  logic [otqe_pkg::BYTES_W-1:0]      req_item_bytes,
   input  logic [otqe_pkg::REF_W-1:0]        req_payload_ref,
   input  logic [otqe_pkg::TICK_W-1:0]       req_now_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_op_ok,
   output logic [otqe_pkg::REF_W-1:0]        rsp_child_ref,
   output logic [otqe_pkg::PORT_PEER_W-1:0]  rsp_child_peer,
   output logic [otqe_pkg::BYTES_W-1:0]      rsp_child_bytes,
   output logic [otqe_pkg::TICK_W-1:0]       rsp_child_added,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [otqe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [otqe_pkg::CSR_DATA_W-1:0]   csr_data
);
   import otqe_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
   localparam int PB_W  = BYTES_W + CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef struct packed {
      logic [TAG_W-1:0]      block;
      logic [TAG_W-1:0]      variant;
      logic [TAG_W-1:0]      parent;
      logic [PEER_WIDTH-1:0] peer;
      logic [BYTES_W-1:0]    bytes;
      logic [TICK_W-1:0]     added;
      logic [REF_W-1:0]      payload;
      logic [ORDER_W-1:0]    order;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control state.
   state_type            state_ff, state_in;
   pass_type             pass_ff, pass_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [ORDER_W-1:0]   order_ff, order_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CFG_CNT_W-1:0] max_cnt_ff, max_cnt_in;
   logic [TOTAL_W-1:0]   max_total_ff, max_total_in;
   logic [CFG_CNT_W-1:0] max_pcnt_ff, max_pcnt_in;
   logic [BYTES_W-1:0]   max_pbytes_ff, max_pbytes_in;
   logic [TICK_W-1:0]    expiry_ff, expiry_in;

   // Request and scan working registers.
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [TAG_W-1:0]      blk_ff, blk_in;
   logic [TAG_W-1:0]      var_ff, var_in;
   logic [TAG_W-1:0]      par_ff, par_in;
   logic [PEER_WIDTH-1:0] peer_ff, peer_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [REF_W-1:0]      pay_ff, pay_in;
   logic [TICK_W-1:0]     now_ff, now_in;
   logic                  flag_ff, flag_in;
   logic                  ok_ff, ok_in;
   logic [CNT_W-1:0]      pcount_ff, pcount_in;
   logic [PB_W-1:0]       pbytes_ff, pbytes_in;
   logic                  best_v_ff, best_v_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [TICK_W-1:0]     best_added_ff, best_added_in;
   logic [TAG_W-1:0]      best_block_ff, best_block_in;
   logic [TAG_W-1:0]      best_variant_ff, best_variant_in;
   logic [ORDER_W-1:0]    best_age_ff, best_age_in;
   logic [REF_W-1:0]      best_pay_ff, best_pay_in;
   logic [PEER_WIDTH-1:0] best_peer_ff, best_peer_in;
   logic [BYTES_W-1:0]    best_bytes_ff, best_bytes_in;
   logic [RES_W-1:0]      take_n_ff, take_n_in;
   logic [RES_W-1:0]      take_k_ff, take_k_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [REF_W-1:0]      rsp_ref_ff, rsp_ref_in;
   logic [PORT_PEER_W-1:0] rsp_peer_ff, rsp_peer_in;
   logic [BYTES_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [TICK_W-1:0]     rsp_added_ff, rsp_added_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Memory port.
   logic                 mem_we;
   entry_type            wr_entry;
   logic [ENTRY_W-1:0]   rd_data;
   entry_type            e;

   // Shared compare unit and decisions.
   logic                 req_acc;
   logic                 v;
   logic [ORDER_W-1:0]   age;
   logic                 expired;
   logic                 older;
   logic                 scan_last;
   logic                 out_free;
   logic [CMP_W-1:0]     cap;
   logic                 caps_fail;
   logic                 peer_fail;
   logic                 oversize;
   logic [RES_W-1:0]     n_take;
   logic                 emit_last;

   otqe_store #(
      .DEPTH  (ENTRIES),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign e         = entry_type'(rd_data);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign v         = valid_ff[idx_ff];
   assign age       = order_ff - e.order;
   assign expired   = v && (now_ff >= e.added) && ((now_ff - e.added) > expiry_ff);
   assign older     = !best_v_ff || (e.added < best_added_ff) ||
                      ((e.added == best_added_ff) &&
                       ((e.block < best_block_ff) ||
                        ((e.block == best_block_ff) && (e.variant < best_variant_ff))));
   assign scan_last = (idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cap       = (CMP_W'(max_cnt_ff) < CMP_W'(ENTRIES)) ? CMP_W'(max_cnt_ff)
                                                               : CMP_W'(ENTRIES);
   assign caps_fail = (CMP_W'(count_ff) >= cap) ||
                      (({1'b0, total_ff} + (TOTAL_W + 1)'(bytes_ff)) > {1'b0, max_total_ff});
   assign peer_fail = flag_ff || (CMP_W'(pcount_ff) >= CMP_W'(max_pcnt_ff)) ||
                      ((pbytes_ff + PB_W'(bytes_ff)) > PB_W'(max_pbytes_ff));
   assign oversize  = req_item_bytes > max_pbytes_ff;
   assign n_take    = (CMP_W'(pcount_ff) > CMP_W'(MAX_RESULTS)) ? RES_W'(MAX_RESULTS)
                                                                 : RES_W'(pcount_ff);
   assign emit_last = (take_k_ff == (take_n_ff - RES_W'(1)));

   assign wr_entry.block   = blk_ff;
   assign wr_entry.variant = var_ff;
   assign wr_entry.parent  = par_ff;
   assign wr_entry.peer    = peer_ff;
   assign wr_entry.bytes   = bytes_ff;
   assign wr_entry.added   = now_ff;
   assign wr_entry.payload = pay_ff;
   assign wr_entry.order   = order_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_opcode == OP_ADD) begin
                  state_in = oversize ? ST_RESP : ST_SCAN_RD;
               end else if (req_opcode == OP_TAKE || req_opcode == OP_CONTAINS) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: state_in = scan_last ? ST_PASS_DONE : ST_SCAN_RD;
         ST_PASS_DONE: begin
            unique case (pass_ff)
               PASS_EXPIRE:   state_in = ST_SCAN_RD;
               PASS_CHECK:    state_in = peer_fail ? ST_RESP : ST_CAPS;
               PASS_EVICT:    state_in = ST_CAPS;
               PASS_CONTAINS: state_in = ST_RESP;
               PASS_COUNT:    state_in = (pcount_ff == '0) ? ST_RESP : ST_SCAN_RD;
               PASS_OLDEST:   state_in = ST_EMIT;
               default:       state_in = ST_IDLE;
            endcase
         end
         ST_CAPS: begin
            if (!caps_fail) begin
               state_in = ST_FREE;
            end else begin
               state_in = (count_ff == '0) ? ST_RESP : ST_SCAN_RD;
            end
         end
         ST_FREE: state_in = v ? ST_FREE : ST_RESP;
         ST_RESP: state_in = out_free ? ST_IDLE : ST_RESP;
         ST_EMIT: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_SCAN_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      pass_in         = pass_ff;
      idx_in          = idx_ff;
      valid_in        = valid_ff;
      count_in        = count_ff;
      total_in        = total_ff;
      order_in        = order_ff;
      op_in           = op_ff;
      blk_in          = blk_ff;
      var_in          = var_ff;
      par_in          = par_ff;
      peer_in         = peer_ff;
      bytes_in        = bytes_ff;
      pay_in          = pay_ff;
      now_in          = now_ff;
      flag_in         = flag_ff;
      ok_in           = ok_ff;
      pcount_in       = pcount_ff;
      pbytes_in       = pbytes_ff;
      best_v_in       = best_v_ff;
      best_idx_in     = best_idx_ff;
      best_added_in   = best_added_ff;
      best_block_in   = best_block_ff;
      best_variant_in = best_variant_ff;
      best_age_in     = best_age_ff;
      best_pay_in     = best_pay_ff;
      best_peer_in    = best_peer_ff;
      best_bytes_in   = best_bytes_ff;
      take_n_in       = take_n_ff;
      take_k_in       = take_k_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_ok_in       = rsp_ok_ff;
      rsp_ref_in      = rsp_ref_ff;
      rsp_peer_in     = rsp_peer_ff;
      rsp_bytes_in    = rsp_bytes_ff;
      rsp_added_in    = rsp_added_ff;
      rsp_last_in     = rsp_last_ff;
      mem_we          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in     = req_opcode;
               blk_in    = req_block_tag;
               var_in    = req_variant_tag;
               par_in    = req_parent_tag;
               peer_in   = PEER_WIDTH'(req_peer_id);
               bytes_in  = req_item_bytes;
               pay_in    = req_payload_ref;
               now_in    = req_now_tick;
               ok_in     = 1'b0;
               idx_in    = '0;
               flag_in   = 1'b0;
               pcount_in = '0;
               pbytes_in = '0;
               best_v_in = 1'b0;
               pass_in   = (req_opcode == OP_CONTAINS) ? PASS_CONTAINS : PASS_EXPIRE;
            end
         end
         ST_SCAN_RD: begin
         end
         ST_SCAN_EV: begin
            unique case (pass_ff)
               PASS_EXPIRE: begin
                  if (expired) begin
                     valid_in[idx_ff] = 1'b0;
                     total_in = total_ff - TOTAL_W'(e.bytes);
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               PASS_CHECK: begin
                  if (v) begin
                     if (e.block == blk_ff && e.variant == var_ff) begin
                        flag_in = 1'b1;
                     end
                     if (e.peer == peer_ff) begin
                        pcount_in = pcount_ff + CNT_W'(1);
                        pbytes_in = pbytes_ff + PB_W'(e.bytes);
                     end
                  end
               end
               PASS_EVICT: begin
                  if (v && older) begin
                     best_v_in       = 1'b1;
                     best_idx_in     = idx_ff;
                     best_added_in   = e.added;
                     best_block_in   = e.block;
                     best_variant_in = e.variant;
                     best_bytes_in   = e.bytes;
                  end
               end
               PASS_CONTAINS: begin
                  if (v && e.block == blk_ff) begin
                     flag_in = 1'b1;
                  end
               end
               PASS_COUNT: begin
                  if (v && e.parent == par_ff) begin
                     pcount_in = pcount_ff + CNT_W'(1);
                  end
               end
               PASS_OLDEST: begin
                  // The child with the largest age against the order counter came first.
                  if (v && e.parent == par_ff && (!best_v_ff || age > best_age_ff)) begin
                     best_v_in     = 1'b1;
                     best_idx_in   = idx_ff;
                     best_age_in   = age;
                     best_pay_in   = e.payload;
                     best_peer_in  = e.peer;
                     best_bytes_in = e.bytes;
                     best_added_in = e.added;
                  end
               end
               default: begin
               end
            endcase
            if (!scan_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_PASS_DONE: begin
            idx_in    = '0;
            flag_in   = 1'b0;
            pcount_in = '0;
            pbytes_in = '0;
            best_v_in = 1'b0;
            unique case (pass_ff)
               PASS_EXPIRE: pass_in = (op_ff == OP_ADD) ? PASS_CHECK : PASS_COUNT;
               PASS_CHECK: begin
                  ok_in = 1'b0;
               end
               PASS_EVICT: begin
                  valid_in[best_idx_ff] = 1'b0;
                  total_in = total_ff - TOTAL_W'(best_bytes_ff);
                  count_in = count_ff - CNT_W'(1);
               end
               PASS_CONTAINS: ok_in = flag_ff;
               PASS_COUNT: begin
                  take_n_in = n_take;
                  take_k_in = '0;
                  ok_in     = 1'b0;
                  pass_in   = PASS_OLDEST;
               end
               PASS_OLDEST: begin
                  best_v_in = best_v_ff;
               end
               default: begin
               end
            endcase
         end
         ST_CAPS: begin
            idx_in    = '0;
            best_v_in = 1'b0;
            pass_in   = PASS_EVICT;
            ok_in     = 1'b0;
         end
         ST_FREE: begin
            if (!v) begin
               mem_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               total_in         = total_ff + TOTAL_W'(bytes_ff);
               order_in         = order_ff + ORDER_W'(1);
               ok_in            = 1'b1;
            end else if (!scan_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_ref_in   = '0;
               rsp_peer_in  = '0;
               rsp_bytes_in = '0;
               rsp_added_in = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_ok_in             = 1'b1;
               rsp_ref_in            = best_pay_ff;
               rsp_peer_in           = PORT_PEER_W'(best_peer_ff);
               rsp_bytes_in          = best_bytes_ff;
               rsp_added_in          = best_added_ff;
               rsp_last_in           = emit_last;
               valid_in[best_idx_ff] = 1'b0;
               total_in              = total_ff - TOTAL_W'(best_bytes_ff);
               count_in              = count_ff - CNT_W'(1);
               take_k_in             = take_k_ff + RES_W'(1);
               idx_in                = '0;
               best_v_in             = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      max_cnt_in    = max_cnt_ff;
      max_total_in  = max_total_ff;
      max_pcnt_in   = max_pcnt_ff;
      max_pbytes_in = max_pbytes_ff;
      expiry_in     = expiry_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ENTRY_COUNT: max_cnt_in    = csr_data[CFG_CNT_W-1:0];
            CSR_MAX_TOTAL_BYTES: max_total_in  = csr_data[TOTAL_W-1:0];
            CSR_MAX_PEER_COUNT:  max_pcnt_in   = csr_data[CFG_CNT_W-1:0];
            CSR_MAX_PEER_BYTES:  max_pbytes_in = csr_data[BYTES_W-1:0];
            CSR_EXPIRY_TICKS:    expiry_in     = csr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= PASS_EXPIRE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         order_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         max_cnt_ff    <= RST_MAX_ENTRY_COUNT;
         max_total_ff  <= RST_MAX_TOTAL_BYTES;
         max_pcnt_ff   <= RST_MAX_PEER_COUNT;
         max_pbytes_ff <= RST_MAX_PEER_BYTES;
         expiry_ff     <= RST_EXPIRY_TICKS;
         best_v_ff     <= 1'b0;
         take_n_ff     <= '0;
         take_k_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         order_ff      <= order_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_cnt_ff    <= max_cnt_in;
         max_total_ff  <= max_total_in;
         max_pcnt_ff   <= max_pcnt_in;
         max_pbytes_ff <= max_pbytes_in;
         expiry_ff     <= expiry_in;
         best_v_ff     <= best_v_in;
         take_n_ff     <= take_n_in;
         take_k_ff     <= take_k_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      blk_ff          <= blk_in;
      var_ff          <= var_in;
      par_ff          <= par_in;
      peer_ff         <= peer_in;
      bytes_ff        <= bytes_in;
      pay_ff          <= pay_in;
      now_ff          <= now_in;
      flag_ff         <= flag_in;
      ok_ff           <= ok_in;
      pcount_ff       <= pcount_in;
      pbytes_ff       <= pbytes_in;
      best_idx_ff     <= best_idx_in;
      best_added_ff   <= best_added_in;
      best_block_ff   <= best_block_in;
      best_variant_ff <= best_variant_in;
      best_age_ff     <= best_age_in;
      best_pay_ff     <= best_pay_in;
      best_peer_ff    <= best_peer_in;
      best_bytes_ff   <= best_bytes_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_ref_ff      <= rsp_ref_in;
      rsp_peer_ff     <= rsp_peer_in;
      rsp_bytes_ff    <= rsp_bytes_in;
      rsp_added_ff    <= rsp_added_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_op_ok       = rsp_ok_ff;
   assign rsp_child_ref   = rsp_ref_ff;
   assign rsp_child_peer  = rsp_peer_ff;
   assign rsp_child_bytes = rsp_bytes_ff;
   assign rsp_child_added = rsp_added_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count disagrees with valid bits");
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !valid_ff[idx_ff])
      else $error("insert overwrote a live slot");
   a_emit_has_child: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_v_ff)
      else $error("emit without a selected child");
`endif

endmodule

// ----- dv/orphan_table_quota_eviction_test.sv -----
// Self-checking testbench for the orphan table with peer quotas and oldest-first eviction.
`timescale 1ns / 100ps

module orphan_table_quota_eviction_test;
   import otqe_pkg::*;

   localparam int SLOTS = 64;
   localparam int IDLE_LIMIT = 40000;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0]    op;
      logic [TAG_W-1:0]       blk;
      logic [TAG_W-1:0]       vrt;
      logic [TAG_W-1:0]       par;
      logic [PORT_PEER_W-1:0] peer;
      logic [BYTES_W-1:0]     bytes;
      logic [REF_W-1:0]       pref;
      logic [TICK_W-1:0]      now;
   } request_type;

   typedef struct {
      logic                   ok;
      logic [REF_W-1:0]       cref;
      logic [PORT_PEER_W-1:0] cpeer;
      logic [BYTES_W-1:0]     cbytes;
      logic [TICK_W-1:0]      cadded;
      logic                   last;
   } outcome_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [OPCODE_W-1:0] req_opcode;
   logic [TAG_W-1:0] req_block_tag, req_variant_tag, req_parent_tag;
   logic [PORT_PEER_W-1:0] req_peer_id;
   logic [BYTES_W-1:0] req_item_bytes;
   logic [REF_W-1:0] req_payload_ref;
   logic [TICK_W-1:0] req_now_tick;
   logic rsp_valid, rsp_stall, rsp_op_ok, rsp_last;
   logic [REF_W-1:0] rsp_child_ref;
   logic [PORT_PEER_W-1:0] rsp_child_peer;
   logic [BYTES_W-1:0] rsp_child_bytes;
   logic [TICK_W-1:0] rsp_child_added;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   orphan_table_quota_eviction dut (.*);

   // Shadow copy of the table and its limits.
   logic [CFG_CNT_W-1:0] lim_entries, lim_peer_count;
   logic [TOTAL_W-1:0]   lim_total_bytes;
   logic [BYTES_W-1:0]   lim_peer_bytes;
   logic [TICK_W-1:0]    lim_expiry;
   bit                   tv[SLOTS];
   logic [TAG_W-1:0]     tblk[SLOTS], tvrt[SLOTS], tpar[SLOTS];
   logic [PORT_PEER_W-1:0] tpeer[SLOTS];
   logic [BYTES_W-1:0]   tbytes[SLOTS];
   logic [TICK_W-1:0]    tadded[SLOTS];
   logic [REF_W-1:0]     tref[SLOTS];
   logic [ORDER_W-1:0]   tord[SLOTS];
   logic [TOTAL_W-1:0]   held_bytes;
   logic [ORDER_W-1:0]   next_order;

   outcome_type pending_results[$];
   int errors = 0, mismatches = 0, sent = 0, checked = 0, phases = 0;
   bit quiet = 0;
   logic [TICK_W-1:0] clock_tick = 48'd0;
   logic [TAG_W-1:0] parent_pool[6], block_pool[12], variant_pool[3];
   logic [PORT_PEER_W-1:0] peer_pool[4];

   // Directed stimulus table; a typed row carries its expected op_ok.
   request_type rows[$];
   bit typed[$];
   logic typed_ok[$];

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void add_row(request_type r, bit known = 0, logic known_ok = 0);
      rows.insert(rows.size(), r);
      typed.insert(typed.size(), known);
      typed_ok.insert(typed_ok.size(), known_ok);
   endfunction

   function automatic void drop_entry(int i);
      tv[i] = 0;
      held_bytes = held_bytes - TOTAL_W'(tbytes[i]);
   endfunction

   function automatic void expire_stale(logic [TICK_W-1:0] now);
      for (int i = 0; i < SLOTS; i++)
         if (tv[i] && now >= tadded[i] && now - tadded[i] > lim_expiry) drop_entry(i);
   endfunction

   function automatic int occupied();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += tv[i];
      return n;
   endfunction

   function automatic void evict_oldest();
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tv[i]) continue;
         if (b < 0 || tadded[i] < tadded[b] || (tadded[i] == tadded[b] &&
             (tblk[i] < tblk[b] || (tblk[i] == tblk[b] && tvrt[i] < tvrt[b])))) b = i;
      end
      if (b >= 0) drop_entry(b);
   endfunction

   function automatic bit table_add(request_type r);
      logic [63:0] pcnt, pbytes, cap;
      int n, fs;
      if (r.bytes > lim_peer_bytes) return 0;
      expire_stale(r.now);
      pcnt = 0;
      pbytes = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tv[i]) continue;
         if (tblk[i] == r.blk && tvrt[i] == r.vrt) return 0;
         if (tpeer[i] == r.peer) begin
            pcnt++;
            pbytes += 64'(tbytes[i]);
         end
      end
      if (pcnt >= 64'(lim_peer_count) || pbytes + 64'(r.bytes) > 64'(lim_peer_bytes)) return 0;
      cap = (lim_entries < SLOTS) ? 64'(lim_entries) : 64'(SLOTS);
      forever begin
         n = occupied();
         if (!(64'(n) >= cap || 64'(held_bytes) + 64'(r.bytes) > 64'(lim_total_bytes))) break;
         if (n == 0) return 0;
         evict_oldest();
      end
      fs = -1;
      for (int i = 0; i < SLOTS; i++)
         if (!tv[i] && fs < 0) fs = i;
      if (fs < 0) return 0;
      tv[fs] = 1;
      tblk[fs] = r.blk;
      tvrt[fs] = r.vrt;
      tpar[fs] = r.par;
      tpeer[fs] = r.peer;
      tbytes[fs] = r.bytes;
      tadded[fs] = r.now;
      tref[fs] = r.pref;
      tord[fs] = next_order;
      next_order++;
      held_bytes = held_bytes + TOTAL_W'(r.bytes);
      return 1;
   endfunction

   function automatic void push_result(logic ok, logic [REF_W-1:0] cr,
         logic [PORT_PEER_W-1:0] cp, logic [BYTES_W-1:0] cb, logic [TICK_W-1:0] ca,
         logic lst);
      outcome_type e;
      e.ok = ok;
      e.cref = cr;
      e.cpeer = cp;
      e.cbytes = cb;
      e.cadded = ca;
      e.last = lst;
      pending_results.insert(pending_results.size(), e);
   endfunction

   function automatic void table_take(request_type r);
      int n, b;
      logic [ORDER_W-1:0] age, bage;
      expire_stale(r.now);
      n = 0;
      for (int i = 0; i < SLOTS; i++)
         if (tv[i] && tpar[i] == r.par) n++;
      if (n > MAX_RESULTS) n = MAX_RESULTS;
      if (n == 0) push_result(0, 0, 0, 0, 0, 1);
      for (int k = 0; k < n; k++) begin
         b = -1;
         bage = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!tv[i] || tpar[i] != r.par) continue;
            age = next_order - tord[i];
            if (b < 0 || age > bage) begin
               b = i;
               bage = age;
            end
         end
         push_result(1, tref[b], tpeer[b], tbytes[b], tadded[b], k == n - 1);
         drop_entry(b);
      end
   endfunction

   function automatic void predict_request(request_type r);
      bit found;
      found = 0;
      case (r.op)
         OP_ADD: push_result(table_add(r), 0, 0, 0, 0, 1);
         OP_TAKE: table_take(r);
         OP_CONTAINS: begin
            for (int i = 0; i < SLOTS; i++)
               if (tv[i] && tblk[i] == r.blk) found = 1;
            push_result(found, 0, 0, 0, 0, 1);
         end
         default: push_result(0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   task automatic send_request(request_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_opcode = r.op;
      req_block_tag = r.blk;
      req_variant_tag = r.vrt;
      req_parent_tag = r.par;
      req_peer_id = r.peer;
      req_item_bytes = r.bytes;
      req_payload_ref = r.pref;
      req_now_tick = r.now;
      req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_ENTRY_COUNT: lim_entries = val[CFG_CNT_W-1:0];
         CSR_MAX_TOTAL_BYTES: lim_total_bytes = val[TOTAL_W-1:0];
         CSR_MAX_PEER_COUNT:  lim_peer_count = val[CFG_CNT_W-1:0];
         CSR_MAX_PEER_BYTES:  lim_peer_bytes = val[BYTES_W-1:0];
         CSR_EXPIRY_TICKS:    lim_expiry = val[TICK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic request_type make_request(logic [OPCODE_W-1:0] op,
         logic [TAG_W-1:0] blk, logic [TAG_W-1:0] vrt, logic [TAG_W-1:0] par,
         logic [PORT_PEER_W-1:0] peer, logic [BYTES_W-1:0] bytes, logic [REF_W-1:0] pref,
         logic [TICK_W-1:0] now);
      request_type r;
      r.op = op;
      r.blk = blk;
      r.vrt = vrt;
      r.par = par;
      r.peer = peer;
      r.bytes = bytes;
      r.pref = pref;
      r.now = now;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic request_type random_request();
      request_type r;
      int sel;
      logic [24:0] hi;
      if ($urandom_range(0, 9) == 0) begin
         // Noise: every field drawn over its whole range.
         return make_request(OPCODE_W'($urandom), rand64(), rand64(), rand64(),
            PORT_PEER_W'($urandom), BYTES_W'($urandom), $urandom, TICK_W'(rand64()));
      end
      sel = $urandom_range(0, 99);
      r.op = sel < 55 ? OP_ADD : sel < 75 ? OP_TAKE : sel < 95 ? OP_CONTAINS : OP_UNUSED;
      r.blk = $urandom_range(0, 4) == 0 ? rand64() : block_pool[$urandom_range(0, 11)];
      r.vrt = variant_pool[$urandom_range(0, 2)];
      r.par = parent_pool[$urandom_range(0, 5)];
      r.peer = $urandom_range(0, 5) == 0 ? PORT_PEER_W'($urandom)
                                         : peer_pool[$urandom_range(0, 3)];
      r.pref = $urandom;
      hi = {1'b0, lim_peer_bytes};
      case ($urandom_range(0, 9))
         0: r.bytes = 0;
         1: r.bytes = lim_peer_bytes;
         2: r.bytes = BYTES_W'(hi + 1);
         3: r.bytes = BYTES_W'($urandom);
         default: r.bytes = BYTES_W'($urandom_range(0, hi / 4 + 1));
      endcase
      // Time mostly creeps forward, with an occasional long jump or step back.
      sel = $urandom_range(0, 99);
      if (sel < 5) clock_tick = clock_tick + TICK_W'($urandom_range(0, 5000));
      else if (sel < 8 && clock_tick > 300) clock_tick = clock_tick - 300;
      else clock_tick = clock_tick + TICK_W'($urandom_range(0, 60));
      r.now = clock_tick;
      return r;
   endfunction

   task automatic run_phase(logic [CFG_CNT_W-1:0] ent, logic [TOTAL_W-1:0] tot,
         logic [CFG_CNT_W-1:0] pcnt, logic [BYTES_W-1:0] pb, logic [TICK_W-1:0] ex, int n);
      drain();
      write_reg(CSR_MAX_ENTRY_COUNT, CSR_DATA_W'(ent));
      write_reg(CSR_MAX_TOTAL_BYTES, CSR_DATA_W'(tot));
      write_reg(CSR_MAX_PEER_COUNT, CSR_DATA_W'(pcnt));
      write_reg(CSR_MAX_PEER_BYTES, CSR_DATA_W'(pb));
      write_reg(CSR_EXPIRY_TICKS, CSR_DATA_W'(ex));
      phases++;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 39) == 0) drain();
         send_request(random_request());
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("ERROR: unexpected result ok=%0d ref=%h", rsp_op_ok, rsp_child_ref);
         end else begin
            e = pending_results.pop_front();
            if (rsp_op_ok !== e.ok || rsp_child_ref !== e.cref || rsp_child_peer !== e.cpeer ||
                rsp_child_bytes !== e.cbytes || rsp_child_added !== e.cadded ||
                rsp_last !== e.last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("MISMATCH exp ok=%0d ref=%h peer=%h bytes=%h added=%h last=%0d\n%s%0d ref=%h peer=%h bytes=%h added=%h last=%0d",
                     e.ok, e.cref, e.cpeer, e.cbytes, e.cadded, e.last, "         got ok=",
                     rsp_op_ok, rsp_child_ref, rsp_child_peer, rsp_child_bytes,
                     rsp_child_added, rsp_last);
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      int idle_cycles;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure in bursts.
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall = 0;
         end else repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_opcode = OP_ADD;
      req_block_tag = 0;
      req_variant_tag = 0;
      req_parent_tag = 0;
      req_peer_id = 0;
      req_item_bytes = 0;
      req_payload_ref = 0;
      req_now_tick = 0;
      csr_valid = 0;
      csr_index = CSR_MAX_ENTRY_COUNT;
      csr_data = 0;
      lim_entries = RST_MAX_ENTRY_COUNT;
      lim_total_bytes = RST_MAX_TOTAL_BYTES;
      lim_peer_count = RST_MAX_PEER_COUNT;
      lim_peer_bytes = RST_MAX_PEER_BYTES;
      lim_expiry = RST_EXPIRY_TICKS;
      for (int i = 0; i < SLOTS; i++) tv[i] = 0;
      held_bytes = 0;
      next_order = 0;
      parent_pool = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd10, 64'd11, 64'h8000_0000_0000_0000,
                      64'd12};
      for (int i = 0; i < 12; i++) block_pool[i] = i < 2 ? {64{i[0]}} : rand64();
      variant_pool = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_0000_1234_5678};
      peer_pool = '{16'd0, 16'hFFFF, 16'd7, 16'd8};
      repeat (8) @(negedge clock);
      reset = 0;

      // Directed rows; only trivially known outcomes are typed in.
      add_row(make_request(OP_CONTAINS, 64'd1, 0, 0, 0, 0, 0, 0), 1, 0);
      add_row(make_request(OP_TAKE, 0, 0, 64'd10, 0, 0, 0, 48'd50), 1, 0);
      add_row(make_request(OP_ADD, 64'd1, 0, 64'd10, 16'd7, 24'hFFFFFF, 32'hAA, 48'd60), 1, 0);
      add_row(make_request(OP_UNUSED, 64'd1, 0, 64'd10, 0, 0, 0, 48'd60), 1, 0);
      add_row(make_request(OP_ADD, 64'd1, 64'd5, 64'd10, 16'd7, 24'd100, 32'h11, 48'd100));
      add_row(make_request(OP_ADD, 64'd1, 64'd5, 64'd10, 16'd7, 24'd100, 32'h12, 48'd101));
      add_row(make_request(OP_ADD, 64'd1, 64'd6, 64'd10, 16'd8, 24'd50, 32'h13, 48'd100));
      add_row(make_request(OP_CONTAINS, 64'd1, 0, 0, 0, 0, 0, 48'd0));
      add_row(make_request(OP_ADD, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 48'd0));
      add_row(make_request(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         64'd10, 16'hFFFF, 24'd1048576, 32'hFFFF_FFFF, 48'd110));
      add_row(make_request(OP_ADD, 64'd3, 0, 64'd10, 16'hFFFF, 24'd1, 32'h14, 48'd120));
      add_row(make_request(OP_TAKE, 0, 0, 64'd10, 0, 0, 0, 48'd130));
      add_row(make_request(OP_CONTAINS, 64'd1, 0, 0, 0, 0, 0, 48'd130));
      // An entry stamped in the future survives a later add at an earlier tick.
      add_row(make_request(OP_ADD, 64'd20, 0, 64'd11, 16'd7, 24'd10, 32'h21, 48'd9000));
      add_row(make_request(OP_ADD, 64'd21, 0, 64'd11, 16'd7, 24'd10, 32'h22, 48'd200));
      add_row(make_request(OP_ADD, 64'd22, 0, 64'd11, 16'd8, 24'd10, 32'h23, 48'd2000));
      add_row(make_request(OP_TAKE, 0, 0, 64'd11, 0, 0, 0, 48'd2100));
      add_row(make_request(OP_ADD, 64'd23, 0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd9, 24'd10,
         32'h24, 48'hFFFF_FFFF_FFFF));
      add_row(make_request(OP_TAKE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0,
         48'hFFFF_FFFF_FFFF));
      add_row(make_request(OP_TAKE, 0, 0, 64'd0, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
      for (int i = 0; i < rows.size(); i++) begin
         send_request(rows[i]);
         if (typed[i]) begin
            void'(pending_results.pop_back());
            push_result(typed_ok[i], 0, 0, 0, 0, 1);
         end
      end
      clock_tick = 48'd3000;

      // Small caps force steady eviction; then maxima, minima, a zero cap, reset values.
      run_phase(7'd8, 30'd5000, 7'd3, 24'd2000, 48'd500, 60);
      run_phase(7'd127, 30'h3FFF_FFFF, 7'd127, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 60);
      run_phase(7'd1, 30'd1, 7'd1, 24'd1, 48'd0, 40);
      run_phase(7'd0, RST_MAX_TOTAL_BYTES, 7'd64, 24'd1000, RST_EXPIRY_TICKS, 12);
      run_phase(RST_MAX_ENTRY_COUNT, RST_MAX_TOTAL_BYTES, RST_MAX_PEER_COUNT,
         RST_MAX_PEER_BYTES, RST_EXPIRY_TICKS, 60);
      run_phase(7'd20, 30'd300000, 7'd64, 24'd100000, 48'd3000, 50);
      quiet = 1;
      run_phase(7'd64, 30'd200000, 7'd64, 24'd40000, 48'd2000, 40);

      drain();
      repeat (200) @(negedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("ERROR: %0d expected results never arrived", pending_results.size());
      end
      $display("Covered %0d requests and %0d results over %0d limit settings,", sent, checked,
         phases);
      $display("including eviction, expiry, quota rejects and multi-child takes.");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/otqe_pkg.sv
rtl/otqe_store.sv
rtl/orphan_table_quota_eviction.sv
dv/orphan_table_quota_eviction_test.sv
